/* rtl/core/lpw_pkg.sv */
`default_nettype none
// ============================================================================
// lpw_pkg: shared types for the line pixel walker
// Holds the operation code that the front end attaches to each queued command.
// ============================================================================

package lpw_pkg;

  // Operation carried through the command queue.
  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } lpw_op_t;

endpackage

`default_nettype wire

/* rtl/core/lpw_if.sv */
`default_nettype none
// ============================================================================
// lpw_if: valid/ready channels of the line pixel walker
// lpw_in_if carries command beats, lpw_out_if carries pixel beats.
// ============================================================================

interface lpw_in_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic                  func;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_end;
  logic [COORD_BITS-1:0] y_end;

  modport source (output valid, func, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, func, x_start, y_start, x_end, y_end, output ready);
endinterface

interface lpw_out_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  valid_res;
  logic                  last;

  modport source (output valid, pixel_x, pixel_y, valid_res, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, valid_res, last, output ready);
endinterface

`default_nettype wire

/* rtl/core/lpw_front.sv */
`default_nettype none
// ============================================================================
// lpw_front: command decode and line setup
// Classifies each command beat and works out deltas and step directions.
// ============================================================================

module lpw_front
  import lpw_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  func,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  input  logic                  q_ready,
  output logic                  q_push,
  output lpw_op_t               op,
  output logic [COORD_BITS-1:0] delta_x,
  output logic [COORD_BITS-1:0] delta_y,
  output logic                  x_decreasing,
  output logic                  y_decreasing
);

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;

  always_comb begin
    op           = func ? OP_STEP : OP_START;
    x_decreasing = !(x_start < x_end);
    y_decreasing = !(y_start < y_end);
    delta_x      = x_decreasing ? (x_start - x_end) : (x_end - x_start);
    delta_y      = y_decreasing ? (y_start - y_end) : (y_end - y_start);
  end

endmodule

`default_nettype wire

/* rtl/core/lpw_queue.sv */
`default_nettype none
// ============================================================================
// lpw_queue: short first-in first-out command queue
// Separates the setup front end from the pixel back end.
// ============================================================================

module lpw_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             pop_valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lpw_back.sv */
`default_nettype none
// ============================================================================
// lpw_back: Bresenham walker and pixel output register
// Holds the line state, advances one pixel per step command, registers result.
// ============================================================================

module lpw_back
  import lpw_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  lpw_op_t               q_op,
  input  logic [COORD_BITS-1:0] q_x_start,
  input  logic [COORD_BITS-1:0] q_y_start,
  input  logic [COORD_BITS-1:0] q_x_end,
  input  logic [COORD_BITS-1:0] q_y_end,
  input  logic [COORD_BITS-1:0] q_delta_x,
  input  logic [COORD_BITS-1:0] q_delta_y,
  input  logic                  q_x_decreasing,
  input  logic                  q_y_decreasing,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic                  valid_res,
  output logic                  last
);

  localparam int EW = COORD_BITS + 2;

  // Line state.
  logic [COORD_BITS-1:0] cur_x, cur_y, end_x, end_y, delta_x, delta_y;
  logic                  x_decreasing, y_decreasing, finished;
  logic signed [EW-1:0]  error_term;

  logic [COORD_BITS-1:0] cur_x_next, cur_y_next, end_x_next, end_y_next;
  logic [COORD_BITS-1:0] delta_x_next, delta_y_next;
  logic                  x_decreasing_next, y_decreasing_next, finished_next;
  logic signed [EW-1:0]  error_term_next;
  logic                  valid_res_next, last_next;

  logic signed [EW:0]    e2, dx_s, dy_s, err_acc;
  logic                  move_x, move_y, at_end;

  assign q_pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    cur_x_next        = cur_x;
    cur_y_next        = cur_y;
    end_x_next        = end_x;
    end_y_next        = end_y;
    delta_x_next      = delta_x;
    delta_y_next      = delta_y;
    x_decreasing_next = x_decreasing;
    y_decreasing_next = y_decreasing;
    error_term_next   = error_term;
    finished_next     = finished;
    valid_res_next    = 1'b0;
    last_next         = 1'b0;

    e2      = {error_term, 1'b0};
    dx_s    = $signed({3'b000, delta_x});
    dy_s    = $signed({3'b000, delta_y});
    move_x  = (e2 > -dy_s);
    move_y  = (e2 < dx_s);
    err_acc = {error_term[EW-1], error_term}
              - (move_x ? dy_s : '0) + (move_y ? dx_s : '0);
    at_end  = 1'b0;

    case (q_op)
      OP_START: begin
        cur_x_next        = q_x_start;
        cur_y_next        = q_y_start;
        end_x_next        = q_x_end;
        end_y_next        = q_y_end;
        delta_x_next      = q_delta_x;
        delta_y_next      = q_delta_y;
        x_decreasing_next = q_x_decreasing;
        y_decreasing_next = q_y_decreasing;
        error_term_next   = $signed({2'b00, q_delta_x}) - $signed({2'b00, q_delta_y});
        at_end            = (q_x_start == q_x_end) && (q_y_start == q_y_end);
        finished_next     = at_end;
        valid_res_next    = 1'b1;
        last_next         = at_end;
      end
      OP_STEP: begin
        if (!finished) begin
          if (move_x) begin
            cur_x_next = x_decreasing ? cur_x - COORD_BITS'(1) : cur_x + COORD_BITS'(1);
          end
          if (move_y) begin
            cur_y_next = y_decreasing ? cur_y - COORD_BITS'(1) : cur_y + COORD_BITS'(1);
          end
          error_term_next = err_acc[EW-1:0];
          at_end          = (cur_x_next == end_x) && (cur_y_next == end_y);
          finished_next   = at_end;
          valid_res_next  = 1'b1;
          last_next       = at_end;
        end
      end
      default: begin
        valid_res_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x        <= '0;
      cur_y        <= '0;
      end_x        <= '0;
      end_y        <= '0;
      delta_x      <= '0;
      delta_y      <= '0;
      x_decreasing <= 1'b0;
      y_decreasing <= 1'b0;
      error_term   <= '0;
      finished     <= 1'b1;
      out_valid    <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_x        <= cur_x_next;
        cur_y        <= cur_y_next;
        end_x        <= end_x_next;
        end_y        <= end_y_next;
        delta_x      <= delta_x_next;
        delta_y      <= delta_y_next;
        x_decreasing <= x_decreasing_next;
        y_decreasing <= y_decreasing_next;
        error_term   <= error_term_next;
        finished     <= finished_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; loads only when a new command is taken.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      pixel_x   <= cur_x_next;
      pixel_y   <= cur_y_next;
      valid_res <= valid_res_next;
      last      <= last_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/line_pixel_walker.sv */
`default_nettype none
// ============================================================================
// line_pixel_walker: Bresenham line rasterizer for all octants
// Start commands load both endpoints and return the start pixel; steps advance
// one pixel and return it, or repeat the held pixel, valid_res low, once done.
// ============================================================================
//
//   Channel  Direction  Beat contents
//   -------  ---------  -------------------------------------------------
//   cmd      in         func, x_start, y_start, x_end, y_end
//   pix      out        pixel_x, pixel_y, valid_res, last
//
// One pixel beat leaves for every command beat taken, in order. A command
// is accepted every clock while the pixel side keeps up; an accepted
// command passes through the two-entry command queue and then the
// walker's output register, whose single add-and-compare step on the
// error term closes the per-pixel loop.
// Synchronous reset empties the queue, drops the output beat and marks no
// line as active. A stall on the pixel side fills the queue, after which
// cmd.ready falls; the front end keeps taking beats until then.

module line_pixel_walker
  import lpw_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic         clk,
  input  logic         rst,
  lpw_in_if.sink       cmd,
  lpw_out_if.source    pix
);

  // Command word kept in the queue: op, endpoints, deltas, directions.
  localparam int QW    = 1 + 6 * COORD_BITS + 2;
  localparam int QDEPTH = 2;

  // Front end outputs.
  logic                  push;
  logic                  push_ready;
  lpw_op_t               f_op;
  logic [COORD_BITS-1:0] f_delta_x, f_delta_y;
  logic                  f_x_decreasing, f_y_decreasing;

  // Queue read side.
  logic [QW-1:0]         q_data;
  logic                  q_valid;
  logic                  q_pop;
  lpw_op_t               q_op;
  logic [COORD_BITS-1:0] q_x_start, q_y_start, q_x_end, q_y_end;
  logic [COORD_BITS-1:0] q_delta_x, q_delta_y;
  logic                  q_x_decreasing, q_y_decreasing;

  // The front end decodes the command and computes the line setup values
  // before they enter the queue, so the walker only has to load them.
  lpw_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .in_valid     (cmd.valid),
    .in_ready     (cmd.ready),
    .func         (cmd.func),
    .x_start      (cmd.x_start),
    .y_start      (cmd.y_start),
    .x_end        (cmd.x_end),
    .y_end        (cmd.y_end),
    .q_ready      (push_ready),
    .q_push       (push),
    .op           (f_op),
    .delta_x      (f_delta_x),
    .delta_y      (f_delta_y),
    .x_decreasing (f_x_decreasing),
    .y_decreasing (f_y_decreasing)
  );

  lpw_queue #(
    .WIDTH (QW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({f_op, cmd.x_start, cmd.y_start, cmd.x_end, cmd.y_end,
                  f_delta_x, f_delta_y, f_x_decreasing, f_y_decreasing}),
    .push_ready (push_ready),
    .pop        (q_pop),
    .pop_data   (q_data),
    .pop_valid  (q_valid)
  );

  // Unpack the queued command word.
  always_comb begin
    q_op           = lpw_op_t'(q_data[QW-1]);
    q_x_start      = q_data[QW-2                -: COORD_BITS];
    q_y_start      = q_data[QW-2-COORD_BITS     -: COORD_BITS];
    q_x_end        = q_data[QW-2-2*COORD_BITS   -: COORD_BITS];
    q_y_end        = q_data[QW-2-3*COORD_BITS   -: COORD_BITS];
    q_delta_x      = q_data[QW-2-4*COORD_BITS   -: COORD_BITS];
    q_delta_y      = q_data[QW-2-5*COORD_BITS   -: COORD_BITS];
    q_x_decreasing = q_data[1];
    q_y_decreasing = q_data[0];
  end

  // The back end owns the line state and the output register; it takes a
  // queued command whenever its output slot is empty or being drained.
  lpw_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_op           (q_op),
    .q_x_start      (q_x_start),
    .q_y_start      (q_y_start),
    .q_x_end        (q_x_end),
    .q_y_end        (q_y_end),
    .q_delta_x      (q_delta_x),
    .q_delta_y      (q_delta_y),
    .q_x_decreasing (q_x_decreasing),
    .q_y_decreasing (q_y_decreasing),
    .out_valid      (pix.valid),
    .out_ready      (pix.ready),
    .pixel_x        (pix.pixel_x),
    .pixel_y        (pix.pixel_y),
    .valid_res      (pix.valid_res),
    .last           (pix.last)
  );

endmodule

`default_nettype wire

/* rtl/core/lpw_checker.sv */
`default_nettype none
// ============================================================================
// lpw_checker: port-level checks for the line pixel walker
// Watches both channels and tracks beats still owed on the pixel side.
// ============================================================================

module lpw_checker #(
  parameter int COORD_BITS = 12
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  cmd_valid,
  input logic                  cmd_ready,
  input logic                  pix_valid,
  input logic                  pix_ready,
  input logic [COORD_BITS-1:0] pixel_x,
  input logic [COORD_BITS-1:0] pixel_y,
  input logic                  valid_res,
  input logic                  last
);

  logic       cmd_beat, pix_beat;
  logic [2:0] owed;

  assign cmd_beat = cmd_valid && cmd_ready;
  assign pix_beat = pix_valid && pix_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      owed <= '0;
    end else if (cmd_beat && !pix_beat) begin
      owed <= owed + 3'd1;
    end else if (pix_beat && !cmd_beat) begin
      owed <= owed - 3'd1;
    end
  end

  // A stalled pixel beat holds its contents.
  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_ready |=> pix_valid && $stable(pixel_x) && $stable(pixel_y)
                                && $stable(valid_res) && $stable(last))
    else $error("pixel beat changed while stalled");

  // Every pixel beat answers an earlier command beat.
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    pix_valid |-> owed != 3'd0)
    else $error("pixel beat without a pending command");

  // Queue plus output register bound the commands in flight.
  a_bounded: assert property (@(posedge clk) disable iff (rst)
    owed <= 3'd3)
    else $error("more commands in flight than the design can hold");

  // The end-of-line flag only comes with a real pixel.
  a_last_real: assert property (@(posedge clk) disable iff (rst)
    pix_valid && last |-> valid_res)
    else $error("last set on a pixel beat past the line end");

  // Nothing is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !pix_valid)
    else $error("pixel beat offered right after reset");

endmodule

bind line_pixel_walker lpw_checker #(
  .COORD_BITS (COORD_BITS)
) u_lpw_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .pix_valid (pix.valid),
  .pix_ready (pix.ready),
  .pixel_x   (pix.pixel_x),
  .pixel_y   (pix.pixel_y),
  .valid_res (pix.valid_res),
  .last      (pix.last)
);

`default_nettype wire

/* bench/line_pixel_walker_tb.sv */
// ============================================================================
// line_pixel_walker_tb: self-checking bench for the Bresenham line walker
// Drives start and step commands through the command channel with bursty
// timing. The pixel channel stalls on a pattern of its own. A scoreboard
// steps a private copy of the line state and checks every pixel beat in
// order.
// ============================================================================

module line_pixel_walker_tb;
  import lpw_pkg::*;

  localparam int CB           = 12;
  localparam int COORD_MAX    = (1 << CB) - 1;
  localparam int RANDOM_BEATS = 600;
  // No handshake at all for this many cycles means the block has hung.
  localparam int QUIET_LIMIT  = 1000;
  // Every owed pixel is back by then, so a short settle is plenty.
  localparam int SETTLE_CYCLES = 10;
  localparam int MAX_REPORTS  = 10;

  // One pixel beat as it leaves the block.
  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic          valid_res;
    logic          last;
  } pixel_t;

  // The scoreboard keeps its own copy of the walker state. Every accepted
  // command advances that copy and queues the pixel that the block owes.
  class pixel_scoreboard;
    logic [CB-1:0]        cur_x, cur_y, end_x, end_y, delta_x, delta_y;
    logic                 x_dec, y_dec, line_done;
    logic signed [CB+1:0] err;
    pixel_t               expected_q[$];
    int                   mismatches;

    function new();
      cur_x      = '0;
      cur_y      = '0;
      end_x      = '0;
      end_y      = '0;
      delta_x    = '0;
      delta_y    = '0;
      x_dec      = 1'b0;
      y_dec      = 1'b0;
      err        = '0;
      line_done  = 1'b1;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_command(lpw_op_t op, logic [CB-1:0] xs, logic [CB-1:0] ys,
                               logic [CB-1:0] xe, logic [CB-1:0] ye);
      int     dx, dy, e, e2;
      pixel_t px;
      if (op == OP_START) begin
        // A start always replaces whatever line is running.
        cur_x     = xs;
        cur_y     = ys;
        end_x     = xe;
        end_y     = ye;
        delta_x   = (xe >= xs) ? xe - xs : xs - xe;
        delta_y   = (ye >= ys) ? ye - ys : ys - ye;
        x_dec     = !(xs < xe);
        y_dec     = !(ys < ye);
        err       = $signed({2'b00, delta_x}) - $signed({2'b00, delta_y});
        line_done = (xs == xe) && (ys == ye);
        px        = {xs, ys, 1'b1, line_done};
      end else if (line_done) begin
        // Stepping a finished line repeats the held pixel, flagged stale.
        px = {cur_x, cur_y, 1'b0, 1'b0};
      end else begin
        dx = int'(delta_x);
        dy = int'(delta_y);
        e  = int'(err);
        e2 = 2 * e;
        if (e2 > -dy) begin
          e     = e - dy;
          cur_x = x_dec ? cur_x - 1'b1 : cur_x + 1'b1;
        end
        if (e2 < dx) begin
          e     = e + dx;
          cur_y = y_dec ? cur_y - 1'b1 : cur_y + 1'b1;
        end
        err       = e[CB+1:0];
        line_done = (cur_x == end_x) && (cur_y == end_y);
        px        = {cur_x, cur_y, 1'b1, line_done};
      end
      expected_q.push_back(px);
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected_q.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("pixel beat with nothing pending: x=%0d y=%0d valid_res=%b last=%b",
                   got.x, got.y, got.valid_res, got.last);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got.x !== want.x || got.y !== want.y ||
          got.valid_res !== want.valid_res || got.last !== want.last) begin
        if (mismatches < MAX_REPORTS)
          $display("pixel mismatch: want x=%0d y=%0d v=%b l=%b, got x=%0d y=%0d v=%b l=%b",
                   want.x, want.y, want.valid_res, want.last,
                   got.x, got.y, got.valid_res, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  lpw_in_if  #(.COORD_BITS(CB)) cmd_if ();
  lpw_out_if #(.COORD_BITS(CB)) pix_if ();

  line_pixel_walker #(
    .COORD_BITS(CB)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .pix(pix_if)
  );

  pixel_scoreboard sb = new();

  // Sender bookkeeping: beats taken so far and beats left in this burst.
  int beats_sent = 0;
  int burst_left = 0;

  // Receiver stall pattern state. Only the ready process touches these.
  int stall_mode = 0;
  int mode_left  = 0;
  int stall_left = 0;
  int phase_cnt  = 0;

  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The pixel side switches between several stall habits: always ready,
  // coin flips, a regular one-in-four stall and occasional long stalls.
  // Each habit lasts a random stretch so that stalls land on every phase
  // of the walk. Ready starts low before the first edge.
  initial begin
    pix_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      phase_cnt++;
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: begin
          pix_if.ready <= 1'b1;
        end
        1: begin
          pix_if.ready <= 1'($urandom_range(0, 1));
        end
        2: begin
          pix_if.ready <= (phase_cnt % 4) != 3;
        end
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            pix_if.ready <= 1'b0;
          end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(4, 20);
            pix_if.ready <= 1'b0;
          end else begin
            pix_if.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Both channels are sampled at the edge on which the beat is taken. The
  // command is noted first so that a result taken on the same edge still
  // finds the queue in order.
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_if.valid && cmd_if.ready)
        sb.note_command(lpw_op_t'(cmd_if.func), cmd_if.x_start, cmd_if.y_start,
                        cmd_if.x_end, cmd_if.y_end);
      if (pix_if.valid && pix_if.ready)
        sb.check_pixel({pix_if.pixel_x, pix_if.pixel_y, pix_if.valid_res, pix_if.last});
    end
  end

  // The watchdog counts cycles with no beat on either channel. The longest
  // legal quiet stretch is a sender gap plus a long pixel stall, far below
  // the limit.
  always @(posedge clk) begin
    if ((cmd_if.valid && cmd_if.ready) || (pix_if.valid && pix_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offers one command beat and returns on the edge that takes it. Bursts
  // of random length are separated by random gaps, and some bursts follow
  // each other with no gap at all.
  task automatic send_beat(lpw_op_t op, logic [CB-1:0] xs, logic [CB-1:0] ys,
                           logic [CB-1:0] xe, logic [CB-1:0] ye);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cmd_if.valid   <= 1'b1;
    cmd_if.func    <= op;
    cmd_if.x_start <= xs;
    cmd_if.y_start <= ys;
    cmd_if.x_end   <= xe;
    cmd_if.y_end   <= ye;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    beats_sent++;
  endtask

  // A step carries junk coordinates, which the block has to ignore.
  task automatic send_step();
    send_beat(OP_STEP, CB'($urandom_range(0, COORD_MAX)), CB'($urandom_range(0, COORD_MAX)),
              CB'($urandom_range(0, COORD_MAX)), CB'($urandom_range(0, COORD_MAX)));
  endtask

  // Holds the sender off until every owed pixel has come back.
  task automatic wait_for_drain();
    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Picks a coordinate, now and then pinned to one edge of the range.
  function automatic int pick_coord();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return COORD_MAX;
    return $urandom_range(0, COORD_MAX);
  endfunction

  // Moves a coordinate by delta in a random direction, turning back when
  // that would leave the range.
  function automatic int offset_coord(int base, int delta);
    int c;
    c = $urandom_range(0, 1) ? base + delta : base - delta;
    if (c > COORD_MAX) c = base - delta;
    if (c < 0) c = base + delta;
    return c;
  endfunction

  // A well-formed line: a start, then a walk to the end. Most walks run
  // to completion and sometimes a little past it; some stop early so that
  // the next start cuts the line off.
  task automatic random_line();
    int span, dx, dy, xs, ys, xe, ye, steps, r;
    r = $urandom_range(0, 99);
    if (r < 70) span = 16;
    else if (r < 95) span = 64;
    else span = 300;
    dx = $urandom_range(0, span);
    dy = $urandom_range(0, span);
    xs = pick_coord();
    ys = pick_coord();
    xe = offset_coord(xs, dx);
    ye = offset_coord(ys, dy);
    send_beat(OP_START, CB'(xs), CB'(ys), CB'(xe), CB'(ye));
    steps = (dx > dy) ? dx : dy;
    r = $urandom_range(0, 99);
    if (r < 15) steps = $urandom_range(0, steps);
    else if (r < 40) steps = steps + $urandom_range(1, 3);
    repeat (steps) send_step();
  endtask

  // A start with unrelated endpoints anywhere in the range, walked only a
  // few pixels before it is abandoned.
  task automatic wild_start();
    send_beat(OP_START, CB'(pick_coord()), CB'(pick_coord()),
              CB'(pick_coord()), CB'(pick_coord()));
    repeat ($urandom_range(0, 6)) send_step();
  endtask

  initial begin
    int r, next_drain;

    // Every input of the block gets a known value before the first edge.
    rst            = 1'b1;
    cmd_if.valid   = 1'b0;
    cmd_if.func    = OP_START;
    cmd_if.x_start = '0;
    cmd_if.y_start = '0;
    cmd_if.x_end   = '0;
    cmd_if.y_end   = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part. A step straight after reset finds no line and must
    // repeat the origin as stale.
    send_step();
    // Single-pixel line, then a step past its end.
    send_beat(OP_START, 12'd5, 12'd5, 12'd5, 12'd5);
    send_step();
    // Full diagonal across the range, cut short by the next start.
    send_beat(OP_START, 12'd0, 12'd0, CB'(COORD_MAX), CB'(COORD_MAX));
    repeat (2) send_step();
    // Shallow line with both coordinates decreasing from the top corner,
    // walked to the end and one step past it.
    send_beat(OP_START, CB'(COORD_MAX), CB'(COORD_MAX), 12'd4092, 12'd4094);
    repeat (4) send_step();
    // Steep line going right and down.
    send_beat(OP_START, 12'd0, CB'(COORD_MAX), 12'd1, 12'd4091);
    repeat (4) send_step();
    // Anti-diagonal across the whole range, aborted after one pixel.
    send_beat(OP_START, CB'(COORD_MAX), 12'd0, 12'd0, CB'(COORD_MAX));
    send_step();
    // Vertical line walked to the end and one step past it.
    send_beat(OP_START, 12'd2, 12'd7, 12'd2, 12'd3);
    repeat (5) send_step();

    // The sender holds off here until every owed pixel is back.
    wait_for_drain();

    // Random part: mostly complete lines, with some wild starts and stray
    // steps mixed in. Every so often the sender waits for a full drain.
    next_drain = beats_sent + 150;
    while (beats_sent < 24 + RANDOM_BEATS) begin
      r = $urandom_range(0, 99);
      if (r < 80) random_line();
      else if (r < 92) wild_start();
      else repeat ($urandom_range(1, 3)) send_step();
      if (beats_sent >= next_drain) begin
        wait_for_drain();
        next_drain = beats_sent + 150;
      end
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
